// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, idle while rst_n is low.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication check on clk: when cond holds, prop must hold.
`define ASSERT_IMPL(name, cond, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== design/dstwr_pkg.sv =====
`default_nettype none

package dstwr_pkg;

    localparam int NUM_PEERS_DEF = 8;
    localparam int HIST_DEPTH    = 3;
    localparam int TS_W          = 32;
    localparam int DIST_W        = 16;
    localparam int MM_W          = 20;
    localparam int DEN_W         = 34;
    localparam int PROD_W        = 64;
    localparam int QUO_W         = 41;
    localparam int Q_W           = 42;
    localparam int ACC_W         = 63;
    localparam int FRAC_SHIFT    = 24;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 20;

    localparam logic [DIST_W-1:0] THRESHOLD_RST = 16'd500;
    localparam logic [MM_W-1:0]   MM_PER_TICK_RST = 20'd307478;
    localparam logic [DIST_W-1:0] OFFSET_RST = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_TICK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

    localparam logic FUNC_TIMESTAMPS = 1'b0;
    localparam logic FUNC_REPORTED   = 1'b1;

    typedef struct packed {
        logic load;
        logic mul;
        logic mag;
        logic div_init;
        logic div_step;
        logic fix;
        logic mul_lo;
        logic mul_hi;
        logic acc;
        logic hist_rd;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic func;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/dstwr_dp.sv =====
`default_nettype none

module dstwr_dp #(
    parameter int NUM_PEERS = dstwr_pkg::NUM_PEERS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire dstwr_pkg::dp_cmd_t                    cmd,
    output dstwr_pkg::dp_stat_t                        stat,
    input  wire logic                                  cfg_we,
    input  wire logic [dstwr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [dstwr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                  func,
    input  wire logic [2:0]                            peer_id,
    input  wire logic [dstwr_pkg::TS_W-1:0]            poll_sent,
    input  wire logic [dstwr_pkg::TS_W-1:0]            poll_received,
    input  wire logic [dstwr_pkg::TS_W-1:0]            answer_sent,
    input  wire logic [dstwr_pkg::TS_W-1:0]            answer_received,
    input  wire logic [dstwr_pkg::TS_W-1:0]            final_sent,
    input  wire logic [dstwr_pkg::TS_W-1:0]            final_received,
    input  wire logic [dstwr_pkg::DIST_W-1:0]          reported_distance,
    output logic [2:0]                                 out_peer,
    output logic [dstwr_pkg::DIST_W-1:0]               raw_distance,
    output logic [dstwr_pkg::DIST_W-1:0]               filtered_distance,
    output logic                                       updated
);
    import dstwr_pkg::*;

    localparam int PW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam int IW = (PW + 1 > 3) ? PW + 1 : 3;

    typedef logic [HIST_DEPTH-1:0][DIST_W-1:0] row_t;

    logic [DIST_W-1:0] thr_reg;
    logic [MM_W-1:0]   mm_reg;
    logic [DIST_W-1:0] off_reg;

    logic              func_reg;
    logic [2:0]        peer_reg;
    logic [TS_W-1:0]   ra_reg, rb_reg, da_reg, db_reg;
    logic [PROD_W-1:0] p1_reg, p2_reg, mag_reg;
    logic [DEN_W-1:0]  den_reg, rem_reg;
    logic              neg_reg, zero_reg, sat_reg;
    logic [QUO_W-1:0]  dvd_reg, quo_reg;
    logic [Q_W-1:0]    q_reg;
    logic [ACC_W-1:0]  prod_reg;
    logic [DIST_W-1:0] raw_reg;

    row_t              mem [NUM_PEERS];
    logic [NUM_PEERS-1:0] vld_reg;
    logic [1:0]        slot_reg [NUM_PEERS];
    row_t              row_rd_reg;
    logic              vld_rd_reg;
    logic [1:0]        slot_rd_reg;
    logic              inrange_reg;

    logic [IW-1:0]     peer_ext;
    logic [PW-1:0]     idx;
    logic              inrange;
    logic [DEN_W:0]    rem_sh;
    logic              qbit;
    logic [DEN_W-1:0]  rem_next;
    logic [40:0]       plo;
    logic [40:0]       phi;
    logic [39:0]       offs;
    logic [ACC_W:0]    tsum;
    logic [ACC_W-1:0]  tdif;
    logic [DIST_W-1:0] acc_dist;
    row_t              hrow;
    logic [DIST_W-1:0] lo, hi, med;
    logic [DIST_W-1:0] diff;
    logic              upd;
    logic [1:0]        slot_new;
    row_t              row_new;

    assign stat.func = func_reg;
    assign peer_ext  = IW'(peer_reg);
    assign idx       = peer_ext[PW-1:0];
    assign inrange   = peer_ext < IW'(NUM_PEERS);

    assign rem_sh   = {rem_reg, dvd_reg[QUO_W-1]};
    assign qbit     = rem_sh >= {1'b0, den_reg};
    assign rem_next = qbit ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];

    assign plo  = q_reg[20:0] * mm_reg;
    assign phi  = q_reg[41:21] * mm_reg;
    assign offs = {off_reg, 24'd0};
    assign tsum = {1'b0, prod_reg} + (ACC_W + 1)'(offs);
    assign tdif = ACC_W'(offs) - prod_reg;

    always_comb
    begin
        if (neg_reg) begin
            if (prod_reg >= ACC_W'(offs))
                acc_dist = '0;
            else
                acc_dist = tdif[FRAC_SHIFT +: DIST_W];
        end else begin
            if (tsum[ACC_W:FRAC_SHIFT] > (ACC_W + 1 - FRAC_SHIFT)'(16'hFFFF))
                acc_dist = 16'hFFFF;
            else
                acc_dist = tsum[FRAC_SHIFT +: DIST_W];
        end
    end

    always_comb
    begin
        hrow     = vld_rd_reg ? row_rd_reg : '0;
        lo       = (hrow[0] < hrow[1]) ? hrow[0] : hrow[1];
        hi       = (hrow[0] < hrow[1]) ? hrow[1] : hrow[0];
        if (hrow[2] <= lo)
            med = lo;
        else if (hrow[2] >= hi)
            med = hi;
        else
            med = hrow[2];
        diff     = (med > raw_reg) ? DIST_W'(med - raw_reg) : DIST_W'(raw_reg - med);
        upd      = (raw_reg != '0) && inrange_reg;
        slot_new = (slot_rd_reg >= 2'd2) ? 2'd0 : 2'(slot_rd_reg + 2'd1);
        row_new  = hrow;
        row_new[slot_new] = raw_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            thr_reg <= THRESHOLD_RST;
            mm_reg  <= MM_PER_TICK_RST;
            off_reg <= OFFSET_RST;
            vld_reg <= '0;
            for (int i = 0; i < NUM_PEERS; i++)
                slot_reg[i] <= 2'd0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_THRESHOLD:   thr_reg <= cfg_data[DIST_W-1:0];
                    REG_MM_PER_TICK: mm_reg  <= cfg_data[MM_W-1:0];
                    REG_OFFSET:      off_reg <= cfg_data[DIST_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.finish && upd) begin
                vld_reg[idx]  <= 1'b1;
                slot_reg[idx] <= slot_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.hist_rd)
            row_rd_reg <= mem[idx];
        if (cmd.finish && upd)
            mem[idx] <= row_new;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            func_reg <= func;
            peer_reg <= peer_id;
            raw_reg  <= reported_distance;
            ra_reg   <= answer_received - poll_sent;
            rb_reg   <= final_received - answer_sent;
            da_reg   <= answer_sent - poll_received;
            db_reg   <= final_sent - answer_received;
        end
        if (cmd.mul) begin
            p1_reg  <= PROD_W'(ra_reg) * PROD_W'(rb_reg);
            p2_reg  <= PROD_W'(da_reg) * PROD_W'(db_reg);
            den_reg <= DEN_W'(ra_reg) + DEN_W'(rb_reg) + DEN_W'(da_reg) + DEN_W'(db_reg);
        end
        if (cmd.mag) begin
            neg_reg <= p2_reg > p1_reg;
            mag_reg <= (p2_reg > p1_reg) ? p2_reg - p1_reg : p1_reg - p2_reg;
        end
        if (cmd.div_init) begin
            zero_reg <= den_reg == '0;
            sat_reg  <= DEN_W'(mag_reg[PROD_W-1:33]) >= den_reg;
            rem_reg  <= DEN_W'(mag_reg[PROD_W-1:33]);
            dvd_reg  <= {mag_reg[32:0], 8'd0};
            quo_reg  <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
        end
        if (cmd.fix) begin
            if (zero_reg)
                q_reg <= '0;
            else if (sat_reg)
                q_reg <= Q_W'(1) << 41;
            else
                q_reg <= {1'b0, quo_reg};
        end
        if (cmd.mul_lo)
            prod_reg <= ACC_W'(plo);
        if (cmd.mul_hi)
            prod_reg <= prod_reg + ACC_W'({phi, 21'd0});
        if (cmd.acc)
            raw_reg <= acc_dist;
        if (cmd.hist_rd) begin
            vld_rd_reg  <= vld_reg[idx];
            slot_rd_reg <= slot_reg[idx];
            inrange_reg <= inrange;
        end
        if (cmd.finish) begin
            out_peer          <= peer_reg;
            raw_distance      <= raw_reg;
            updated           <= upd;
            filtered_distance <= !upd ? '0 : ((diff > thr_reg) ? med : raw_reg);
        end
    end

endmodule

`default_nettype wire

// ===== design/dstwr_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module dstwr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire dstwr_pkg::dp_stat_t  stat,
    output dstwr_pkg::dp_cmd_t        cmd
);
    import dstwr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MAG, S_DINIT, S_DIV, S_FIX,
        S_MLO, S_MHI, S_ACC, S_HRD, S_FILT
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (stat.func == FUNC_REPORTED) begin
                    state_next = S_HRD;
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = S_MAG;
                end
            end
            S_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = 6'(cnt_reg + 6'd1);
                if (cnt_reg == 6'(QUO_W - 1))
                    state_next = S_FIX;
            end
            S_FIX:
            begin
                cmd.fix    = 1'b1;
                state_next = S_MLO;
            end
            S_MLO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MHI;
            end
            S_MHI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_HRD;
            end
            S_HRD:
            begin
                cmd.hist_rd = 1'b1;
                state_next  = S_FILT;
            end
            S_FILT:
            begin
                if (out_free) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_CLK(a_one_cmd, $onehot0(cmd), "more than one datapath command")
    `ASSERT_CLK(a_finish_valid, cmd.finish |=> out_valid, "finished result not presented")
    `ASSERT_IMPL(a_fix_after_div, cmd.fix, $past(cmd.div_step), "fix without division")
    `ASSERT_IMPL(a_no_overwrite, cmd.finish, !out_valid_reg || out_ready, "result overwritten")

endmodule

`default_nettype wire

// ===== design/ds_twr_range_median_filter.sv =====
// Flow: a timestamp item passes load, multiply, magnitude, the 41-step restoring
// divider, fix, scaling and accumulate, then history read and filter; a reported item
// goes from load straight to history read and filter. One item is taken at a time:
// the next is accepted once the result sits in the output register, even if it waits.
// Reset: rst_n is asynchronous, clears control, registers to defaults, and marks
// every peer history row invalid (reads as zero) with its insert slot at zero.
`default_nettype none

module ds_twr_range_median_filter #(
    parameter int NUM_PEERS = dstwr_pkg::NUM_PEERS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [dstwr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dstwr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              func,
    input  wire logic [2:0]                        peer_id,
    input  wire logic [dstwr_pkg::TS_W-1:0]        poll_sent,
    input  wire logic [dstwr_pkg::TS_W-1:0]        poll_received,
    input  wire logic [dstwr_pkg::TS_W-1:0]        answer_sent,
    input  wire logic [dstwr_pkg::TS_W-1:0]        answer_received,
    input  wire logic [dstwr_pkg::TS_W-1:0]        final_sent,
    input  wire logic [dstwr_pkg::TS_W-1:0]        final_received,
    input  wire logic [dstwr_pkg::DIST_W-1:0]      reported_distance,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [2:0]                             out_peer,
    output logic [dstwr_pkg::DIST_W-1:0]           raw_distance,
    output logic [dstwr_pkg::DIST_W-1:0]           filtered_distance,
    output logic                                   updated
);
    import dstwr_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dstwr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dstwr_dp #(
        .NUM_PEERS (NUM_PEERS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .func              (func),
        .peer_id           (peer_id),
        .poll_sent         (poll_sent),
        .poll_received     (poll_received),
        .answer_sent       (answer_sent),
        .answer_received   (answer_received),
        .final_sent        (final_sent),
        .final_received    (final_received),
        .reported_distance (reported_distance),
        .out_peer          (out_peer),
        .raw_distance      (raw_distance),
        .filtered_distance (filtered_distance),
        .updated           (updated)
    );

endmodule

`default_nettype wire
